// ===== hdl/pds_pkg.sv =====
// Package for the polynomial distribution sampler: payload structs, register indexes
// and the controller-to-datapath command and status types. No dependencies.
`default_nettype none
package pds_pkg;

    typedef struct packed {
        logic [31:0] select_random;
        logic [31:0] position_random;
    } pds_in_t;

    typedef struct packed {
        logic [31:0] sample_value;
        logic [1:0]  chosen_term;
        logic        limits_bad;
    } pds_out_t;

    localparam logic [2:0] REG_LOWER  = 3'd0;
    localparam logic [2:0] REG_UPPER  = 3'd1;
    localparam logic [2:0] REG_TERMS  = 3'd2;
    localparam logic [2:0] REG_CUM0   = 3'd3;
    localparam logic [2:0] REG_CUM1   = 3'd4;
    localparam logic [2:0] REG_CUM2   = 3'd5;

    // Operand selection for a power evaluation.
    typedef enum logic [1:0] {
        SRC_LOWER = 2'd0,
        SRC_UPPER = 2'd1,
        SRC_CAND  = 2'd2
    } pds_src_t;

    typedef struct packed {
        logic     load;      // latch input item, choose term
        logic     pow_init;  // start a power with chosen source
        pds_src_t pow_src;
        logic     pow_step;  // one half of a multiply step
        logic     save_lo;   // power result is lower^n
        logic     save_hi;   // power result is upper^n
        logic     mix_lo;    // diff * position, low half product
        logic     mix_hi;    // high half product and final argument
        logic     root_init; // clear root, set bit pointer to 31
        logic     root_cand; // form candidate for current bit
        logic     root_dec;  // compare candidate power, advance bit
        logic     finish;    // present result
    } pds_cmd_t;

    typedef struct packed {
        logic       pow_done;
        logic       root_last;
        logic       bad;
    } pds_stat_t;

endpackage
`default_nettype wire

// ===== hdl/pds_ctrl.sv =====
// Controller state machine of the polynomial distribution sampler.
// Depends on pds_pkg for the command and status structs.
`default_nettype none
module pds_ctrl
    import pds_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire pds_stat_t stat,
    output pds_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_LO_INIT, S_LO_RUN, S_HI_INIT, S_HI_RUN,
        S_MIX_LO, S_MIX_HI, S_ROOT_INIT, S_CAND, S_CAND_RUN, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.pow_src = SRC_LOWER;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // The item is latched at the edge that accepts it.
                    cmd.load = 1'b1;
                    state_next = S_LO_INIT;
                end
            end
            S_LO_INIT:
            begin
                if (stat.bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.pow_init = 1'b1;
                    cmd.pow_src = SRC_LOWER;
                    state_next = S_LO_RUN;
                end
            end
            S_LO_RUN:
            begin
                if (stat.pow_done)
                begin
                    cmd.save_lo = 1'b1;
                    state_next = S_HI_INIT;
                end
                else
                begin
                    cmd.pow_step = 1'b1;
                end
            end
            S_HI_INIT:
            begin
                cmd.pow_init = 1'b1;
                cmd.pow_src = SRC_UPPER;
                state_next = S_HI_RUN;
            end
            S_HI_RUN:
            begin
                if (stat.pow_done)
                begin
                    cmd.save_hi = 1'b1;
                    state_next = S_MIX_LO;
                end
                else
                begin
                    cmd.pow_step = 1'b1;
                end
            end
            S_MIX_LO:
            begin
                cmd.mix_lo = 1'b1;
                state_next = S_MIX_HI;
            end
            S_MIX_HI:
            begin
                cmd.mix_hi = 1'b1;
                state_next = S_ROOT_INIT;
            end
            S_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                state_next = S_CAND;
            end
            S_CAND:
            begin
                cmd.root_cand = 1'b1;
                cmd.pow_init = 1'b1;
                cmd.pow_src = SRC_CAND;
                state_next = S_CAND_RUN;
            end
            S_CAND_RUN:
            begin
                if (stat.pow_done)
                begin
                    cmd.root_dec = 1'b1;
                    state_next = stat.root_last ? S_DONE : S_CAND;
                end
                else
                begin
                    cmd.pow_step = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/pds_datapath.sv =====
// Datapath of the polynomial distribution sampler: configuration registers, term choice,
// a shared 32x32 multiplier for powers and mixing, and the bitwise root. Uses pds_pkg.
`default_nettype none
module pds_datapath
    import pds_pkg::*;
#(
    parameter int MAX_TERMS     = 4,
    parameter int FRACTION_BITS = 28
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire pds_in_t     item,
    input  wire pds_cmd_t    cmd,
    output pds_stat_t        stat,
    output logic             result_valid,
    output pds_out_t         result
);

    localparam logic [63:0] SAT = {64{1'b1}};
    localparam logic [2:0]  MAX_T = 3'(MAX_TERMS);

    logic [31:0] lower_reg, upper_reg, cum0_reg, cum1_reg, cum2_reg;
    logic [2:0]  terms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= 32'(1) << FRACTION_BITS;
            terms_reg <= 3'd1;
            cum0_reg  <= '1;
            cum1_reg  <= '1;
            cum2_reg  <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOWER: lower_reg <= cfg_data;
                REG_UPPER: upper_reg <= cfg_data;
                REG_TERMS: terms_reg <= cfg_data[2:0];
                REG_CUM0:  cum0_reg  <= cfg_data;
                REG_CUM1:  cum1_reg  <= cfg_data;
                REG_CUM2:  cum2_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Term selection, done when the item is loaded.
    logic [2:0] terms_eff;
    logic [1:0] k_sel;
    always_comb
    begin
        terms_eff = terms_reg;
        if (terms_eff == 3'd0)
        begin
            terms_eff = 3'd1;
        end
        if (terms_eff > MAX_T)
        begin
            terms_eff = MAX_T;
        end
        k_sel = 2'(terms_eff - 3'd1);
        if (terms_eff > 3'd1 && item.select_random < cum0_reg)
        begin
            k_sel = 2'd0;
        end
        else if (terms_eff > 3'd2 && item.select_random < cum1_reg)
        begin
            k_sel = 2'd1;
        end
        else if (terms_eff > 3'd3 && item.select_random < cum2_reg)
        begin
            k_sel = 2'd2;
        end
    end

    logic [31:0] pos_reg;
    logic [1:0]  k_reg;
    logic        bad_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg <= item.position_random;
            k_reg   <= k_sel;
            bad_reg <= (lower_reg >= upper_reg);
        end
    end

    // Power unit: p = x; repeat n-1 times p = (p*x) >> FRACTION_BITS, saturating.
    // Each multiply step works in two halves: low half, then high half of p.
    logic [31:0] root_reg, cand_reg;
    logic [4:0]  bit_reg;
    logic [31:0] x_reg;
    logic [63:0] p_reg;
    logic [1:0]  cnt_reg;   // steps still to do
    logic        phase_reg;
    logic [63:0] plo_reg;   // low-half product

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    assign prod = 64'(mul_a) * 64'(mul_b);

    logic [63:0] diff_reg, lo_p_reg, arg_reg;

    always_comb
    begin
        mul_b = x_reg;
        mul_a = phase_reg ? p_reg[63:32] : p_reg[31:0];
        if (cmd.mix_lo || cmd.mix_hi)
        begin
            mul_b = pos_reg;
            mul_a = cmd.mix_hi ? diff_reg[63:32] : diff_reg[31:0];
        end
    end

    // Combine the halves: (hi<<32 + lo) >> s with saturation.
    function automatic logic [63:0] combine(input logic [63:0] hi, input logic [63:0] lo,
                                            input int s);
        logic [95:0] w;
        w = ({32'd0, hi} << 32) + {32'd0, lo};
        w = w >> s;
        if (w[95:64] != '0)
        begin
            return SAT;
        end
        return w[63:0];
    endfunction

    logic [31:0] src_x;
    always_comb
    begin
        case (cmd.pow_src)
            SRC_LOWER: src_x = lower_reg;
            SRC_UPPER: src_x = upper_reg;
            SRC_CAND:  src_x = root_reg | (32'd1 << bit_reg);
            default:   src_x = lower_reg;
        endcase
    end

    assign stat.pow_done  = (cnt_reg == 2'd0) || (p_reg == SAT);
    assign stat.root_last = (bit_reg == 5'd0);
    assign stat.bad       = bad_reg;

    logic [63:0] mix_sum;
    assign mix_sum = combine(prod, plo_reg, 32) + lo_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            phase_reg    <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.finish;
            if (cmd.pow_init)
            begin
                cnt_reg   <= k_reg;
                phase_reg <= 1'b0;
            end
            else if (cmd.pow_step)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    cnt_reg <= cnt_reg - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pow_init)
        begin
            x_reg <= src_x;
            p_reg <= {32'd0, src_x};
        end
        else if (cmd.pow_step)
        begin
            if (!phase_reg)
            begin
                plo_reg <= prod;
            end
            else
            begin
                p_reg <= combine(prod, plo_reg, FRACTION_BITS);
            end
        end
        if (cmd.root_cand)
        begin
            cand_reg <= src_x;
        end
        if (cmd.save_lo)
        begin
            lo_p_reg <= p_reg;
        end
        if (cmd.save_hi)
        begin
            diff_reg <= (p_reg >= lo_p_reg) ? p_reg - lo_p_reg : 64'd0;
        end
        if (cmd.mix_lo)
        begin
            plo_reg <= prod;
        end
        if (cmd.mix_hi)
        begin
            arg_reg <= (mix_sum < lo_p_reg) ? SAT : mix_sum;
        end
        if (cmd.root_init)
        begin
            root_reg <= '0;
            bit_reg  <= 5'd31;
        end
        if (cmd.root_dec)
        begin
            if (p_reg <= arg_reg)
            begin
                root_reg <= cand_reg;
            end
            bit_reg <= bit_reg - 5'd1;
        end
        if (cmd.finish)
        begin
            result.sample_value <= bad_reg ? lower_reg : root_reg;
            result.chosen_term  <= k_reg;
            result.limits_bad   <= bad_reg;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/polynomial_distribution_sampler.sv =====
// Top level of the polynomial distribution sampler: joins the controller and datapath.
// Depends on pds_pkg, pds_ctrl and pds_datapath.
`default_nettype none
// The block draws one sample per transaction from a polynomial density of up to four
// terms. A transaction is accepted at a clock edge with start high and busy low, and the
// item is captured at that same edge; busy then stays high until the result has been
// shown. The result is on the result port for exactly one cycle with done high, and the
// receiver cannot stall it, so it must be taken at once. The duration of a transaction
// is set by the single 32x32 multiplier, which evaluates every power in steps of a low
// half and then a high half, and by the bitwise root, which tests one of the 32 result
// bits per power evaluation. A power that saturates stops early, so a transaction can be
// shorter. When the limits are bad, the controller goes from S_LO_INIT straight to S_DONE
// and no power is evaluated. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while the block is idle, as the block itself
// does not enforce this. There is no read-back.
module polynomial_distribution_sampler
    import pds_pkg::*;
#(
    parameter int MAX_TERMS     = 4,
    parameter int FRACTION_BITS = 28
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire pds_in_t     item,
    output logic             done,
    output pds_out_t         result
);

    pds_cmd_t  cmd;
    pds_stat_t stat;
    logic      ctrl_busy;

    // The controller sequences the datapath through one transaction at a time.
    pds_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (ctrl_busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pds_datapath #(
        .MAX_TERMS     (MAX_TERMS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (done),
        .result       (result)
    );

    // Busy is high in every controller state other than idle.
    assign busy = ctrl_busy;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the polynomial distribution sampler.
// Depends on pds_pkg and polynomial_distribution_sampler; drives directed rows, then random draws.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import pds_pkg::*;

    localparam int FRAC = 28;
    localparam logic [63:0] SAT = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_LOWER;
    logic [31:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    pds_in_t     item = '0;
    logic        done;
    pds_out_t    result;

    // Shadow copy of the configuration, updated as each register is written.
    logic [31:0] lower_q, upper_q, cum_q [3];
    logic [2:0]  terms_q;

    pds_out_t expected_samples [$];
    int       mismatches = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    polynomial_distribution_sampler i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .item(item),
        .done(done), .result(result)
    );

    // (a * b) >> s with saturation, as the block forms its products.
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [31:0] b, int s);
        logic [127:0] full;
        full = ({64'd0, a} * {96'd0, b}) >> s;
        return (full[127:64] != 0) ? SAT : full[63:0];
    endfunction

    function automatic logic [63:0] fixed_power(logic [31:0] x, int n);
        logic [63:0] p;
        p = {32'd0, x};
        for (int i = 1; i < n; i++)
        begin
            if (p != SAT)
                p = scaled_product(p, x, FRAC);
        end
        return p;
    endfunction

    function automatic pds_out_t predict_sample(pds_in_t t);
        pds_out_t    r;
        int          terms, k;
        logic [63:0] lo_p, hi_p, arg, lifted;
        logic [31:0] root, cand;
        terms = (terms_q < 1) ? 1 : (terms_q > 4) ? 4 : terms_q;
        k = terms - 1;
        for (int i = 0; i + 1 < terms; i++)
        begin
            if (t.select_random < cum_q[i])
            begin
                k = i;
                break;
            end
        end
        r.chosen_term = k[1:0];
        r.limits_bad = (lower_q >= upper_q);
        if (r.limits_bad)
            r.sample_value = lower_q;
        else
        begin
            lo_p = fixed_power(lower_q, k + 1);
            hi_p = fixed_power(upper_q, k + 1);
            arg = scaled_product((hi_p >= lo_p) ? hi_p - lo_p : 64'd0, t.position_random, 32);
            lifted = arg + lo_p;
            arg = (lifted < lo_p) ? SAT : lifted;
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                cand = root | (32'd1 << b);
                if (fixed_power(cand, k + 1) <= arg)
                    root = cand;
            end
            r.sample_value = root;
        end
        return r;
    endfunction

    // Results are sampled at the rising edge that ends their single valid cycle.
    always @(posedge clk)
    begin
        pds_out_t want;
        if (rst_n && done)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: sample %h term %0d bad %b",
                             result.sample_value, result.chosen_term, result.limits_bad);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 want.sample_value, want.chosen_term, want.limits_bad,
                                 result.sample_value, result.chosen_term, result.limits_bad);
                end
            end
        end
    end

    task automatic write_register(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            REG_LOWER: lower_q = value;
            REG_UPPER: upper_q = value;
            REG_TERMS: terms_q = value[2:0];
            REG_CUM0:  cum_q[0] = value;
            REG_CUM1:  cum_q[1] = value;
            REG_CUM2:  cum_q[2] = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_distribution(logic [31:0] lo, logic [31:0] hi, logic [2:0] n,
                                    logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
        write_register(REG_LOWER, lo);
        write_register(REG_UPPER, hi);
        write_register(REG_TERMS, n);
        write_register(REG_CUM0, w0);
        write_register(REG_CUM1, w1);
        write_register(REG_CUM2, w2);
    endtask

    // Sends one transaction; an optional gap of idle cycles comes first. Start is held
    // until the edge at which busy is seen low, and that edge accepts the transaction.
    task automatic send_draw(pds_in_t t, bit may_idle, bit have_expected, pds_out_t want);
        if (may_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) @(posedge clk);
        @(posedge clk);
        start <= 1'b1;
        item <= t;
        do
            @(posedge clk);
        while (busy);
        expected_samples.push_back(have_expected ? want : predict_sample(t));
        start <= 1'b0;
    endtask

    task automatic drain_results;
        while (expected_samples.size() != 0)
            @(posedge clk);
        // Margin after the last result, before the configuration is written again.
        repeat (20) @(posedge clk);
    endtask

    typedef struct {
        pds_in_t  draw;
        bit       typed;
        pds_out_t want;
    } directed_row_t;

    initial
    begin
        directed_row_t rows [$];
        pds_in_t       t;
        int            total;

        lower_q = '0;
        upper_q = 32'h1000_0000;
        terms_q = 3'd1;
        cum_q = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // After reset: uniform on [0, 1), so position u gives u itself in Q4.28.
        rows = '{
            '{'{32'h0, 32'h0}, 1, '{32'h0, 2'd0, 1'b0}},
            '{'{32'hFFFF_FFFF, 32'h8000_0000}, 1, '{32'h0800_0000, 2'd0, 1'b0}},
            '{'{32'h1234_5678, 32'hFFFF_FFFF}, 0, '0},
            '{'{32'h0, 32'h4000_0000}, 1, '{32'h0400_0000, 2'd0, 1'b0}}
        };
        foreach (rows[i])
            send_draw(rows[i].draw, 0, rows[i].typed, rows[i].want);
        drain_results();

        // Four terms, increasing weights: each term chosen, extremes of both words.
        set_distribution(32'h0800_0000, 32'h2000_0000, 3'd4,
                         32'h4000_0000, 32'h8000_0000, 32'hC000_0000);
        rows = '{
            '{'{32'h0, 32'h0}, 0, '0},
            '{'{32'h3FFF_FFFF, 32'hFFFF_FFFF}, 0, '0},
            '{'{32'h4000_0000, 32'h0}, 0, '0},
            '{'{32'h8000_0000, 32'hFFFF_FFFF}, 0, '0},
            '{'{32'hC000_0000, 32'h5555_5555}, 0, '0},
            '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, '0}
        };
        foreach (rows[i])
            send_draw(rows[i].draw, 0, rows[i].typed, rows[i].want);
        drain_results();

        // Bad limits: the lower limit comes back with the flag, term still chosen.
        set_distribution(32'h3000_0000, 32'h3000_0000, 3'd2,
                         32'h8000_0000, 32'h0, 32'h0);
        send_draw('{32'h0, 32'hFFFF_FFFF}, 0, 1, '{32'h3000_0000, 2'd0, 1'b1});
        send_draw('{32'hFFFF_FFFF, 32'h0}, 0, 1, '{32'h3000_0000, 2'd1, 1'b1});
        drain_results();

        // Widest limits; term count zero behaves as one, so each power is the limit itself.
        set_distribution(32'h0, 32'hFFFF_FFFF, 3'd0, 32'h0, 32'h0, 32'h0);
        send_draw('{32'h0, 32'hFFFF_FFFF}, 0, 0, '0);
        send_draw('{32'hFFFF_FFFF, 32'h1}, 0, 0, '0);
        drain_results();

        // Term counts above four are clipped; weights that fall apply first-match.
        set_distribution(32'hF000_0000, 32'hFFFF_FFFF, 3'd7,
                         32'hFFFF_FFFF, 32'h1000_0000, 32'h0);
        send_draw('{32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, 0, '0);
        send_draw('{32'h0800_0000, 32'h0}, 0, 0, '0);
        send_draw('{32'h8000_0000, 32'h8000_0000}, 0, 0, '0);
        drain_results();

        // Random phases, each with a fresh distribution. Most limits are well formed;
        // a few are inverted or equal, and a few span the whole range.
        total = 0;
        while (total < 1400)
        begin
            logic [31:0] lo, hi;
            int          kind;
            kind = $urandom_range(0, 9);
            lo = $urandom_range(0, 32'h3000_0000);
            hi = lo + $urandom_range(1, 32'h5000_0000);
            if (kind == 0)
                hi = lo;
            else if (kind == 1)
                {lo, hi} = {$urandom(), $urandom()};
            else if (kind == 2)
                hi = 32'hFFFF_FFFF - $urandom_range(0, 15);
            set_distribution(lo, hi, 3'($urandom_range(0, 7)),
                             $urandom(), $urandom(), $urandom());
            repeat ($urandom_range(20, 80))
            begin
                t.select_random = $urandom();
                t.position_random = ($urandom_range(0, 7) == 0)
                                    ? {32{$urandom_range(0, 1) == 1}} : $urandom();
                // The last stretch runs with no idle gaps.
                send_draw(t, total < 1200, 0, '0);
                total++;
            end
            drain_results();
        end

        drain_results();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // About 1500 transactions, with gaps and writes.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
